// File: sv/rnsbfv_pkg.sv
package rnsbfv_pkg;

    localparam int MAX_MODULI_DEF = 16;
    localparam int WORD_BITS_DEF  = 61;
    localparam int CFG_IDX_W      = 3;
    localparam int COUNT_W        = 5;
    localparam int SLOT_FIELD_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_MOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_MOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QINV_T     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QINV_GAMMA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GINV_T     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULI     = 3'd5;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

// File: sv/rnsbfv_front.sv
module rnsbfv_front #(
    parameter int MAX_MODULI = 16,
    parameter int WORD_BITS  = 61,
    parameter int ITEM_W     = 4 * 61 + 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [rnsbfv_pkg::SLOT_FIELD_W-1:0]   i_table_slot,
    input  logic [WORD_BITS-1:0]                  i_table_modulus,
    input  logic [WORD_BITS-1:0]                  i_table_inv_factor,
    input  logic [WORD_BITS-1:0]                  i_table_qi_t,
    input  logic [WORD_BITS-1:0]                  i_table_gamma_factor,
    input  logic [WORD_BITS-1:0]                  i_ct0_residue,
    input  logic [WORD_BITS-1:0]                  i_ct1_residue,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output logic [ITEM_W-1:0]                     o_item
);
    import rnsbfv_pkg::*;

    logic              r_valid;
    logic [ITEM_W-1:0] r_item;
    logic [ITEM_W-1:0] n_item;
    logic              slot_ok;
    logic              accept;

    // slot_ok drops load slots beyond the table depth
    assign slot_ok = (32'(i_table_slot) < MAX_MODULI);
    assign n_item = {i_req_type, slot_ok, i_table_slot,
                     i_table_gamma_factor, i_table_qi_t,
                     i_req_type ? i_ct1_residue : i_table_inv_factor,
                     i_req_type ? i_ct0_residue : i_table_modulus};

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: sv/rnsbfv_queue.sv
module rnsbfv_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);
    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: sv/rnsbfv_modalu.sv
module rnsbfv_modalu #(
    parameter int WORD_BITS = 61
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rnsbfv_pkg::t_alu_req    i_req,
    input  logic [WORD_BITS-1:0]    i_a,
    input  logic [WORD_BITS-1:0]    i_b,
    input  logic [WORD_BITS-1:0]    i_m,
    output logic                    o_done,
    output logic [WORD_BITS-1:0]    o_res
);
    import rnsbfv_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        A_IDLE,
        A_REDA,
        A_REDB,
        A_DBL,
        A_ACC
    } t_state;

    t_state         r_state;
    t_alu_op        r_op;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_x;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [W-1:0]   r_m;
    logic           r_done;
    logic [W-1:0]   r_res;

    logic [W-1:0]   step_v;
    logic [W-1:0]   dbl_v;
    logic [W-1:0]   acc_v;
    logic           last;

    function automatic logic [W-1:0] f_step(input logic [W-1:0] acc, input logic b,
                                            input logic [W-1:0] m);
        logic [W:0] v;
        v = {acc, b};
        if (v >= {1'b0, m}) begin
            v = v - {1'b0, m};
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
        logic [W:0] v;
        v = {1'b0, a} + {1'b0, b};
        if (v >= {1'b0, m}) begin
            v = v - {1'b0, m};
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
        logic [W:0] v;
        v = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            v = v + {1'b0, m};
        end
        return v[W-1:0];
    endfunction

    assign step_v = f_step(r_acc, r_x[W-1], r_m);
    assign dbl_v  = f_add(r_acc, r_acc, r_m);
    assign acc_v  = r_x[W-1] ? f_add(r_acc, r_a, r_m) : r_acc;
    assign last   = (r_cnt == CW'(W - 1));
    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_m   <= i_m;
                        r_x   <= i_a;
                        r_b   <= i_b;
                        r_acc <= '0;
                        r_cnt <= '0;
                        if (i_m == '0) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_state <= A_REDA;
                        end
                    end
                end
                A_REDA: begin
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + CW'(1);
                    r_acc <= step_v;
                    if (last) begin
                        r_a     <= step_v;
                        r_acc   <= '0;
                        r_x     <= r_b;
                        r_cnt   <= '0;
                        r_state <= A_REDB;
                    end
                end
                A_REDB: begin
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + CW'(1);
                    r_acc <= step_v;
                    if (last) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        unique case (r_op)
                            ALU_ADD: begin
                                r_res   <= f_add(r_a, step_v, r_m);
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end
                            ALU_SUB: begin
                                r_res   <= f_sub(r_a, step_v, r_m);
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end
                            ALU_MUL: begin
                                r_x     <= step_v;
                                r_state <= A_DBL;
                            end
                            default: begin
                                r_res   <= '0;
                                r_done  <= 1'b1;
                                r_state <= A_IDLE;
                            end
                        endcase
                    end
                end
                A_DBL: begin
                    r_acc   <= dbl_v;
                    r_state <= A_ACC;
                end
                A_ACC: begin
                    r_acc <= acc_v;
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (last) begin
                        r_res   <= acc_v;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        r_state <= A_DBL;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

endmodule

// File: sv/rnsbfv_back.sv
module rnsbfv_back #(
    parameter int MAX_MODULI = 16,
    parameter int WORD_BITS  = 61,
    parameter int ITEM_W     = 4 * 61 + 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rnsbfv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [WORD_BITS-1:0]                i_cfg_data,
    input  logic                                i_q_empty,
    input  logic [ITEM_W-1:0]                   i_q_item,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [WORD_BITS-1:0]                o_plain_coeff
);
    import rnsbfv_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int SLOT_W = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;
    localparam int CMP_W  = ((SLOT_W > COUNT_W) ? SLOT_W : COUNT_W) + 1;

    typedef enum logic [4:0] {
        B_IDLE, B_LOAD, B_RD, B_ADD, B_MT, B_MG, B_MI, B_TT, B_AT, B_TG, B_AG,
        B_FST, B_FSG, B_BR, B_H1, B_H2, B_L1, B_GI, B_OUT
    } t_state;

    logic [W-1:0] r_mem_m  [MAX_MODULI];
    logic [W-1:0] r_mem_i  [MAX_MODULI];
    logic [W-1:0] r_mem_ft [MAX_MODULI];
    logic [W-1:0] r_mem_fg [MAX_MODULI];

    logic [W-1:0]       r_t, r_g, r_qt, r_qg, r_gi;
    logic [COUNT_W-1:0] r_moduli;

    t_state             r_state;
    logic               r_wait;
    logic [ITEM_W-1:0]  r_item;
    logic [SLOT_W-1:0]  r_cnt;
    logic [W-1:0]       r_m, r_inv, r_ft, r_fg;
    logic [W-1:0]       r_s, r_u, r_st;
    logic [W-1:0]       r_sum_t, r_sum_g;
    logic               r_ov;
    logic [W-1:0]       r_res;

    logic               it_slot_ok;
    logic [SLOT_W-1:0]  it_slot;
    logic [W-1:0]       it_w0, it_w1, it_w2, it_w3;
    logic [CMP_W-1:0]   cnt_raw, cnt_eff;
    logic               more;

    t_alu_req           alu_req;
    logic               alu_op_state;
    logic [W-1:0]       alu_a, alu_b, alu_m;
    logic               alu_done;
    logic [W-1:0]       alu_res;

    assign it_slot_ok = r_item[4*W+4];
    assign it_slot    = SLOT_W'(r_item[4*W+3:4*W]);
    assign it_w0      = r_item[W-1:0];
    assign it_w1      = r_item[2*W-1:W];
    assign it_w2      = r_item[3*W-1:2*W];
    assign it_w3      = r_item[4*W-1:3*W];

    assign cnt_raw = CMP_W'(r_moduli);
    always_comb begin
        priority if (cnt_raw == '0) begin
            cnt_eff = CMP_W'(1);
        end else if (cnt_raw > CMP_W'(MAX_MODULI)) begin
            cnt_eff = CMP_W'(MAX_MODULI);
        end else begin
            cnt_eff = cnt_raw;
        end
    end
    assign more = ((CMP_W'(r_cnt) + CMP_W'(1)) < cnt_eff);

    assign o_pop         = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid   = r_ov;
    assign o_plain_coeff = r_res;

    always_comb begin
        alu_op_state = 1'b1;
        alu_req.op   = ALU_MUL;
        alu_a        = r_s;
        alu_b        = r_t;
        alu_m        = r_t;
        unique case (r_state)
            B_ADD: begin alu_req.op = ALU_ADD; alu_a = it_w0; alu_b = it_w1; alu_m = r_m; end
            B_MT:  begin alu_b = r_t;   alu_m = r_m; end
            B_MG:  begin alu_b = r_g;   alu_m = r_m; end
            B_MI:  begin alu_b = r_inv; alu_m = r_m; end
            B_TT:  begin alu_b = r_ft;  alu_m = r_t; end
            B_AT:  begin alu_req.op = ALU_ADD; alu_a = r_sum_t; alu_b = r_u; alu_m = r_t; end
            B_TG:  begin alu_b = r_fg;  alu_m = r_g; end
            B_AG:  begin alu_req.op = ALU_ADD; alu_a = r_sum_g; alu_b = r_u; alu_m = r_g; end
            B_FST: begin alu_a = r_sum_t; alu_b = r_qt; alu_m = r_t; end
            B_FSG: begin alu_a = r_sum_g; alu_b = r_qg; alu_m = r_g; end
            B_H1:  begin alu_req.op = ALU_SUB; alu_a = r_g;  alu_b = r_s; alu_m = r_t; end
            B_H2:  begin alu_req.op = ALU_ADD; alu_a = r_st; alu_b = r_u; alu_m = r_t; end
            B_L1:  begin alu_req.op = ALU_SUB; alu_a = r_st; alu_b = r_s; alu_m = r_t; end
            B_GI:  begin alu_a = r_u; alu_b = r_gi; alu_m = r_t; end
            default: alu_op_state = 1'b0;
        endcase
        alu_req.start = alu_op_state && !r_wait;
    end

    rnsbfv_modalu #(
        .WORD_BITS (W)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_m     (alu_m),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t      <= W'(65537);
            r_g      <= W'(2);
            r_qt     <= '0;
            r_qg     <= '0;
            r_gi     <= '0;
            r_moduli <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAIN_MOD:  r_t      <= i_cfg_data;
                CFG_GAMMA_MOD:  r_g      <= i_cfg_data;
                CFG_QINV_T:     r_qt     <= i_cfg_data;
                CFG_QINV_GAMMA: r_qg     <= i_cfg_data;
                CFG_GINV_T:     r_gi     <= i_cfg_data;
                CFG_MODULI:     r_moduli <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_LOAD && it_slot_ok) begin
            r_mem_m[it_slot]  <= it_w0;
            r_mem_i[it_slot]  <= it_w1;
            r_mem_ft[it_slot] <= it_w2;
            r_mem_fg[it_slot] <= it_w3;
        end
        if (r_state == B_RD) begin
            r_m   <= r_mem_m[r_cnt];
            r_inv <= r_mem_i[r_cnt];
            r_ft  <= r_mem_ft[r_cnt];
            r_fg  <= r_mem_fg[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_wait  <= 1'b0;
            r_cnt   <= '0;
            r_sum_t <= '0;
            r_sum_g <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (alu_req.start) begin
                r_wait <= 1'b1;
            end else if (alu_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_item  <= i_q_item;
                        r_state <= i_q_item[4*W+5] ? B_RD : B_LOAD;
                    end
                end
                B_LOAD: r_state <= B_IDLE;
                B_RD:   r_state <= B_ADD;
                B_BR:   r_state <= (r_s > (r_g >> 1)) ? B_H1 : B_L1;
                B_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_res   <= r_u;
                        r_ov    <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    if (r_wait && alu_done) begin
                        unique case (r_state)
                            B_ADD: begin r_s <= alu_res; r_state <= B_MT; end
                            B_MT:  begin r_s <= alu_res; r_state <= B_MG; end
                            B_MG:  begin r_s <= alu_res; r_state <= B_MI; end
                            B_MI:  begin r_s <= alu_res; r_state <= B_TT; end
                            B_TT:  begin r_u <= alu_res; r_state <= B_AT; end
                            B_AT:  begin r_sum_t <= alu_res; r_state <= B_TG; end
                            B_TG:  begin r_u <= alu_res; r_state <= B_AG; end
                            B_AG: begin
                                r_sum_g <= alu_res;
                                if (more) begin
                                    r_cnt   <= r_cnt + SLOT_W'(1);
                                    r_state <= B_IDLE;
                                end else begin
                                    r_state <= B_FST;
                                end
                            end
                            B_FST: begin r_st <= alu_res; r_state <= B_FSG; end
                            B_FSG: begin r_s  <= alu_res; r_state <= B_BR; end
                            B_H1:  begin r_u  <= alu_res; r_state <= B_H2; end
                            B_H2:  begin r_u  <= alu_res; r_state <= B_GI; end
                            B_L1:  begin r_u  <= alu_res; r_state <= B_GI; end
                            B_GI: begin
                                r_u     <= alu_res;
                                r_sum_t <= '0;
                                r_sum_g <= '0;
                                r_cnt   <= '0;
                                r_state <= B_OUT;
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

// File: sv/rns_bfv_decrypt_scale_round_top.sv
// Channel  | handshake                  | payload
// in       | i_in_valid / o_in_stall    | i_req_type .. i_ct1_residue
// out      | o_out_valid / i_out_stall  | o_plain_coeff
// cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A residue takes five modular multiplies and three adds; the last residue of a
// coefficient adds three more multiplies and a rounding correction. All of it
// runs on the one bit-serial modular unit.
// Synchronous active-low reset; tables are undefined until loaded.
// Input and output stall independently through the two-entry item queue.
module rns_bfv_decrypt_scale_round_top #(
    parameter int MAX_MODULI = rnsbfv_pkg::MAX_MODULI_DEF,
    parameter int WORD_BITS  = rnsbfv_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rnsbfv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [WORD_BITS-1:0]                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [rnsbfv_pkg::SLOT_FIELD_W-1:0] i_table_slot,
    input  logic [WORD_BITS-1:0]                i_table_modulus,
    input  logic [WORD_BITS-1:0]                i_table_inv_factor,
    input  logic [WORD_BITS-1:0]                i_table_qi_t,
    input  logic [WORD_BITS-1:0]                i_table_gamma_factor,
    input  logic [WORD_BITS-1:0]                i_ct0_residue,
    input  logic [WORD_BITS-1:0]                i_ct1_residue,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [WORD_BITS-1:0]                o_plain_coeff
);
    import rnsbfv_pkg::*;

    localparam int ITEM_W = 4 * WORD_BITS + SLOT_FIELD_W + 2;

    logic              push, pop, q_full, q_empty;
    logic [ITEM_W-1:0] f_item, q_item;

    rnsbfv_front #(
        .MAX_MODULI (MAX_MODULI),
        .WORD_BITS  (WORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_req_type           (i_req_type),
        .i_table_slot         (i_table_slot),
        .i_table_modulus      (i_table_modulus),
        .i_table_inv_factor   (i_table_inv_factor),
        .i_table_qi_t         (i_table_qi_t),
        .i_table_gamma_factor (i_table_gamma_factor),
        .i_ct0_residue        (i_ct0_residue),
        .i_ct1_residue        (i_ct1_residue),
        .i_q_full             (q_full),
        .o_push               (push),
        .o_item               (f_item)
    );

    rnsbfv_queue #(
        .DW (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rnsbfv_back #(
        .MAX_MODULI (MAX_MODULI),
        .WORD_BITS  (WORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_q_empty     (q_empty),
        .i_q_item      (q_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_plain_coeff (o_plain_coeff)
    );

endmodule
